### hw/rtl/svg_pkg.sv
// ----------------------------------------------------------------------------
// svg_pkg
// Shared types, widths and constants of the UV sphere vertex generator.
// ----------------------------------------------------------------------------
package svg_pkg;

   localparam int IDX_W      = 11;
   localparam int RAD_W      = 16;
   localparam int POS_W      = 25;
   localparam int TEX_W      = 17;
   localparam int ANG_W      = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int ATAN_MAX   = 24;
   localparam int DIV_LAT    = 34;
   localparam int POST_LAT   = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_SUBDIV = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LAYOUT = 2'd2;

   localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

   localparam logic signed [POS_W-1:0] POS_MAX = 25'sd16777215;
   localparam logic signed [POS_W-1:0] POS_MIN = -25'sd16777216;

   typedef struct packed {
      logic [IDX_W-1:0] ring;
      logic [IDX_W-1:0] seg;
      logic             err;
   } svg_item_type;

   typedef struct packed {
      logic [IDX_W-1:0] subdiv;
      logic [IDX_W-2:0] half;
      logic [RAD_W-1:0] radius;
      logic             textured;
   } svg_cfg_type;

   // atan(2^-i) in 2^-32 turns
   function automatic logic [31:0] atan_turns(input int i);
      logic [31:0] t;
      begin
         case (i)
            0:  t = 32'h20000000;
            1:  t = 32'h12E4051E;
            2:  t = 32'h09FB385B;
            3:  t = 32'h051111D4;
            4:  t = 32'h028B0D43;
            5:  t = 32'h0145D7E1;
            6:  t = 32'h00A2F61E;
            7:  t = 32'h00517C55;
            8:  t = 32'h0028BE53;
            9:  t = 32'h00145F2F;
            10: t = 32'h000A2F98;
            11: t = 32'h000517CC;
            12: t = 32'h00028BE6;
            13: t = 32'h000145F3;
            14: t = 32'h0000A2F9;
            15: t = 32'h0000517D;
            16: t = 32'h000028BE;
            17: t = 32'h0000145F;
            18: t = 32'h00000A30;
            19: t = 32'h00000518;
            20: t = 32'h0000028C;
            21: t = 32'h00000146;
            22: t = 32'h000000A3;
            23: t = 32'h00000051;
            default: t = 32'h0;
         endcase
         return t;
      end
   endfunction

endpackage

### hw/rtl/svg_front.sv
// ----------------------------------------------------------------------------
// svg_front
// Accepts vertex items, flags out-of-range indexes and queues them.
// ----------------------------------------------------------------------------
module svg_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [svg_pkg::IDX_W-1:0] req_ring_index,
   input  logic [svg_pkg::IDX_W-1:0] req_segment_index,
   input  svg_pkg::svg_cfg_type      cfg,
   input  logic                      pop,
   output logic                      head_valid,
   output svg_pkg::svg_item_type     head
);
   import svg_pkg::*;

   localparam int QD = 4;
   localparam int PW = 2;

   svg_item_type q_ff [QD];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PW:0]   cnt_ff;
   svg_item_type  item_in;
   logic          push;

   always_comb begin
      item_in.err  = (req_ring_index > cfg.subdiv) || (req_segment_index > cfg.subdiv);
      // error items run with zero indexes; outputs are forced to zero later
      item_in.ring = item_in.err ? '0 : req_ring_index;
      item_in.seg  = item_in.err ? '0 : req_segment_index;
   end

   assign req_ready  = (cnt_ff != (PW+1)'(QD));
   assign push       = req_valid && req_ready;
   assign head_valid = (cnt_ff != '0);
   assign head       = q_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (push && !pop)      cnt_ff <= cnt_ff + 1'b1;
         else if (pop && !push) cnt_ff <= cnt_ff - 1'b1;
      end
   end

endmodule

### hw/rtl/svg_div.sv
// ----------------------------------------------------------------------------
// svg_div
// Pipelined restoring divider: index/S as a turn phase and a Q1.16 ratio,
// both rounded half up. One quotient bit per stage.
// ----------------------------------------------------------------------------
module svg_div #(
   parameter int FRAC = 32
) (
   input  logic                      clock,
   input  logic                      en,
   input  logic [svg_pkg::IDX_W-1:0] num,
   input  logic [svg_pkg::IDX_W-1:0] s,
   input  logic [svg_pkg::IDX_W-2:0] half,
   output logic [svg_pkg::ANG_W-1:0] ang_out,
   output logic [svg_pkg::TEX_W-1:0] tex_out
);
   import svg_pkg::*;

   localparam int LAST = DIV_LAT - 1;
   localparam int TAP  = 16;

   logic [IDX_W-1:0] rem_ff [0:FRAC];
   logic [32:0]      quo_ff [0:FRAC];
   logic [TEX_W-1:0] tex_ff [TAP+1:LAST];
   logic [ANG_W-1:0] ang_ff [FRAC+1:LAST];
   logic             tex_rnd, ang_rnd;

   assign tex_rnd = ({1'b0, rem_ff[TAP]} + {2'b0, half}) >= {1'b0, s};
   assign ang_rnd = ({1'b0, rem_ff[FRAC]} + {2'b0, half}) >= {1'b0, s};

   always_ff @(posedge clock) begin
      if (en) begin
         if (num >= s) begin
            rem_ff[0] <= num - s;
            quo_ff[0] <= 33'd1;
         end else begin
            rem_ff[0] <= num;
            quo_ff[0] <= 33'd0;
         end
      end
   end

   for (genvar k = 0; k < FRAC; k++) begin : g_bit
      logic [IDX_W:0] rem2;
      logic           b;
      assign rem2 = {rem_ff[k], 1'b0};
      assign b    = rem2 >= {1'b0, s};
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1] <= b ? IDX_W'(rem2 - {1'b0, s}) : rem2[IDX_W-1:0];
            quo_ff[k+1] <= {quo_ff[k][31:0], b};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tex_ff[TAP+1]  <= quo_ff[TAP][TEX_W-1:0] + TEX_W'(tex_rnd);
         ang_ff[FRAC+1] <= ANG_W'(quo_ff[FRAC] + 33'(ang_rnd));
      end
   end

   for (genvar k = TAP + 2; k <= LAST; k++) begin : g_tex
      always_ff @(posedge clock) begin
         if (en) tex_ff[k] <= tex_ff[k-1];
      end
   end

   for (genvar k = FRAC + 2; k <= LAST; k++) begin : g_ang
      always_ff @(posedge clock) begin
         if (en) ang_ff[k] <= ang_ff[k-1];
      end
   end

   assign tex_out = tex_ff[LAST];
   assign ang_out = ang_ff[LAST];

endmodule

### hw/rtl/svg_cordic.sv
// ----------------------------------------------------------------------------
// svg_cordic
// Pipelined rotation-mode CORDIC, cosine and sine with 30 fraction bits.
// ----------------------------------------------------------------------------
module svg_cordic #(
   parameter int STEPS = 16
) (
   input  logic                      clock,
   input  logic                      en,
   input  logic [svg_pkg::ANG_W-1:0] ang,
   output logic signed [31:0]        cos_out,
   output logic signed [31:0]        sin_out
);
   import svg_pkg::*;

   logic signed [32:0] x_ff [0:STEPS];
   logic signed [32:0] y_ff [0:STEPS];
   logic signed [32:0] z_ff [0:STEPS-1];
   logic               flip_ff [0:STEPS];
   logic               flip;
   logic [ANG_W-1:0]   a;

   // second or third quarter: rotate by half a turn, negate at the end
   assign flip = ang[31] ^ ang[30];
   assign a    = flip ? {~ang[31], ang[30:0]} : ang;

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= CORDIC_GAIN;
         y_ff[0]    <= '0;
         z_ff[0]    <= {a[31], a};
         flip_ff[0] <= flip;
      end
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      logic               d;
      logic signed [32:0] at;
      assign d  = !z_ff[i][32];
      assign at = $signed({1'b0, atan_turns(i)});
      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i+1]    <= d ? x_ff[i] - (y_ff[i] >>> i) : x_ff[i] + (y_ff[i] >>> i);
            y_ff[i+1]    <= d ? y_ff[i] + (x_ff[i] >>> i) : y_ff[i] - (x_ff[i] >>> i);
            flip_ff[i+1] <= flip_ff[i];
         end
      end
      if (i < STEPS - 1) begin : g_z
         always_ff @(posedge clock) begin
            if (en) z_ff[i+1] <= d ? z_ff[i] - at : z_ff[i] + at;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cos_out <= 32'(flip_ff[STEPS] ? -x_ff[STEPS] : x_ff[STEPS]);
         sin_out <= 32'(flip_ff[STEPS] ? -y_ff[STEPS] : y_ff[STEPS]);
      end
   end

endmodule

### hw/rtl/svg_back.sv
// ----------------------------------------------------------------------------
// svg_back
// Back end: angle dividers, two CORDICs, radius scaling and the result
// register. All stages move together when the result register can load.
// ----------------------------------------------------------------------------
module svg_back #(
   parameter int STEPS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  svg_pkg::svg_cfg_type             cfg,
   input  logic                             head_valid,
   input  svg_pkg::svg_item_type            head,
   output logic                             pop,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [svg_pkg::POS_W-1:0] rsp_pos_x,
   output logic signed [svg_pkg::POS_W-1:0] rsp_pos_y,
   output logic signed [svg_pkg::POS_W-1:0] rsp_pos_z,
   output logic [svg_pkg::TEX_W-1:0]        rsp_tex_u,
   output logic [svg_pkg::TEX_W-1:0]        rsp_tex_v,
   output logic                             rsp_index_error
);
   import svg_pkg::*;

   localparam int CLAT = STEPS + 2;
   localparam int TEX0 = DIV_LAT;
   localparam int LAT  = DIV_LAT + CLAT + POST_LAT;

   logic adv;
   logic vld_ff [0:LAT-1];
   logic err_ff [0:LAT-1];
   logic [TEX_W-1:0] tu_ff [TEX0:LAT-1];
   logic [TEX_W-1:0] tv_ff [TEX0:LAT-1];

   logic [ANG_W-1:0] th, ph;
   logic [TEX_W-1:0] du, dv;
   logic signed [31:0] ct, st, cp, sp;

   logic [30:0]        r_ff;
   logic signed [31:0] cp_ff, sp_ff, ct_ff;
   logic signed [63:0] mx_ff, mz_ff;
   logic signed [32:0] my_ff;
   logic signed [63:0] tx, tz;
   logic signed [32:0] ty;
   logic signed [18:0] ux_ff, uy_ff, uz_ff;
   logic signed [18:0] vx_ff, vy_ff, vz_ff;
   logic signed [35:0] sx_ff, sy_ff, sz_ff;

   logic rsp_valid_ff;
   logic signed [POS_W-1:0] px_ff, py_ff, pz_ff;
   logic [TEX_W-1:0] u_ff, v_ff;
   logic e_ff;

   function automatic logic signed [POS_W-1:0] fit(input logic signed [35:0] p,
                                                   input logic signed [18:0] u,
                                                   input logic textured);
      logic signed [35:0] t;
      logic signed [POS_W-1:0] o;
      begin
         t = (p + 36'sd128) >>> 8;
         if (!textured)                          o = POS_W'(u);
         else if (t > 36'(POS_MAX))              o = POS_MAX;
         else if (t < 36'(POS_MIN))              o = POS_MIN;
         else                                    o = POS_W'(t);
         return o;
      end
   endfunction

   assign adv = !rsp_valid_ff || rsp_ready;
   assign pop = adv && head_valid;

   svg_div #(.FRAC(31)) u_div_ring (
      .clock(clock), .en(adv), .num(head.ring), .s(cfg.subdiv), .half(cfg.half),
      .ang_out(th), .tex_out(dv)
   );
   svg_div #(.FRAC(32)) u_div_seg (
      .clock(clock), .en(adv), .num(head.seg), .s(cfg.subdiv), .half(cfg.half),
      .ang_out(ph), .tex_out(du)
   );
   svg_cordic #(.STEPS(STEPS)) u_cordic_th (
      .clock(clock), .en(adv), .ang(th), .cos_out(ct), .sin_out(st)
   );
   svg_cordic #(.STEPS(STEPS)) u_cordic_ph (
      .clock(clock), .en(adv), .ang(ph), .cos_out(cp), .sin_out(sp)
   );

   // valid and error flags ride alongside the data stages
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= head_valid;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) err_ff[0] <= head.err;
   end

   for (genvar k = 1; k < LAT; k++) begin : g_flag
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) err_ff[k] <= err_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tu_ff[TEX0] <= du;
         tv_ff[TEX0] <= dv;
      end
   end
   for (genvar k = TEX0 + 1; k < LAT; k++) begin : g_tex
      always_ff @(posedge clock) begin
         if (adv) begin
            tu_ff[k] <= tu_ff[k-1];
            tv_ff[k] <= tv_ff[k-1];
         end
      end
   end

   always_comb begin
      tx = -mx_ff + 64'sd8796093022208;
      tz = mz_ff + 64'sd8796093022208;
      ty = my_ff + 33'sd8192;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r_ff  <= st[31] ? 31'(-st) : st[30:0];
         cp_ff <= cp;
         sp_ff <= sp;
         ct_ff <= ct;

         mx_ff <= 64'(cp_ff * $signed({1'b0, r_ff}));
         mz_ff <= 64'(sp_ff * $signed({1'b0, r_ff}));
         my_ff <= -33'(ct_ff);

         ux_ff <= 19'(tx >>> 44);
         uz_ff <= 19'(tz >>> 44);
         uy_ff <= 19'(ty >>> 14);

         // unit position kept in step with the scaled one
         vx_ff <= ux_ff;
         vy_ff <= uy_ff;
         vz_ff <= uz_ff;
         sx_ff <= 36'(ux_ff * $signed({1'b0, cfg.radius}));
         sy_ff <= 36'(uy_ff * $signed({1'b0, cfg.radius}));
         sz_ff <= 36'(uz_ff * $signed({1'b0, cfg.radius}));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= vld_ff[LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_ff <= err_ff[LAT-1];
         if (err_ff[LAT-1]) begin
            px_ff <= '0;
            py_ff <= '0;
            pz_ff <= '0;
            u_ff  <= '0;
            v_ff  <= '0;
         end else begin
            px_ff <= fit(sx_ff, vx_ff, cfg.textured);
            py_ff <= fit(sy_ff, vy_ff, cfg.textured);
            pz_ff <= fit(sz_ff, vz_ff, cfg.textured);
            u_ff  <= cfg.textured ? tu_ff[LAT-1] : '0;
            v_ff  <= cfg.textured ? tv_ff[LAT-1] : '0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pos_x       = px_ff;
   assign rsp_pos_y       = py_ff;
   assign rsp_pos_z       = pz_ff;
   assign rsp_tex_u       = u_ff;
   assign rsp_tex_v       = v_ff;
   assign rsp_index_error = e_ff;

endmodule

### hw/rtl/uv_sphere_vertex_generator.sv
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator
// Position and texture coordinates of one UV sphere vertex per item.
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    ring and segment index
//   rsp      out        rsp_valid/rsp_ready    pos x/y/z, tex u/v, index_error
//   csr      in         csr_valid/csr_ready    csr_index, csr_wdata
//
// One item per cycle sustained while results are taken. From acceptance to
// rsp_valid, items pass through the queue, the two 34-stage dividers and
// the CORDIC pipelines. A 4-entry queue sits between front and back; the back
// stalls as a whole while a result waits. Reset clears queue and valids.
// ----------------------------------------------------------------------------
module uv_sphere_vertex_generator #(
   parameter int MAX_SUBDIVISIONS = 1024,
   parameter int CORDIC_STEPS     = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [svg_pkg::IDX_W-1:0]           req_ring_index,
   input  logic [svg_pkg::IDX_W-1:0]           req_segment_index,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [svg_pkg::POS_W-1:0]    rsp_pos_x,
   output logic signed [svg_pkg::POS_W-1:0]    rsp_pos_y,
   output logic signed [svg_pkg::POS_W-1:0]    rsp_pos_z,
   output logic [svg_pkg::TEX_W-1:0]           rsp_tex_u,
   output logic [svg_pkg::TEX_W-1:0]           rsp_tex_v,
   output logic                                rsp_index_error,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [svg_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [svg_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import svg_pkg::*;

   localparam int STEPS = (CORDIC_STEPS > ATAN_MAX) ? ATAN_MAX : CORDIC_STEPS;
   localparam logic [IDX_W-1:0] SMAX =
      (MAX_SUBDIVISIONS > 2047) ? 11'd2047 : IDX_W'(MAX_SUBDIVISIONS);

   logic [IDX_W-1:0] subdiv_ff;
   logic [RAD_W-1:0] radius_ff;
   logic             textured_ff;
   logic [IDX_W-1:0] s_eff;
   svg_cfg_type      cfg;
   logic             head_valid, pop;
   svg_item_type     head;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         subdiv_ff   <= 11'd48;
         radius_ff   <= 16'd256;
         textured_ff <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_SUBDIV: subdiv_ff   <= csr_wdata[IDX_W-1:0];
            CSR_RADIUS: radius_ff   <= csr_wdata;
            CSR_LAYOUT: textured_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (subdiv_ff == '0)        s_eff = 11'd1;
      else if (subdiv_ff > SMAX)  s_eff = SMAX;
      else                        s_eff = subdiv_ff;
      cfg.subdiv   = s_eff;
      cfg.half     = s_eff[IDX_W-1:1];
      cfg.radius   = radius_ff;
      cfg.textured = textured_ff;
   end

   svg_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_ring_index(req_ring_index), .req_segment_index(req_segment_index),
      .cfg(cfg), .pop(pop), .head_valid(head_valid), .head(head)
   );

   svg_back #(.STEPS(STEPS)) u_back (
      .clock(clock), .reset(reset), .cfg(cfg),
      .head_valid(head_valid), .head(head), .pop(pop),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_pos_x(rsp_pos_x), .rsp_pos_y(rsp_pos_y), .rsp_pos_z(rsp_pos_z),
      .rsp_tex_u(rsp_tex_u), .rsp_tex_v(rsp_tex_v),
      .rsp_index_error(rsp_index_error)
   );

endmodule

### hw/rtl/svg_checker.sv
// ----------------------------------------------------------------------------
// svg_port_checks
// Port-level checks of the vertex generator, bound to the top level.
// ----------------------------------------------------------------------------
module svg_port_checks (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic signed [svg_pkg::POS_W-1:0] rsp_pos_x,
   input logic signed [svg_pkg::POS_W-1:0] rsp_pos_y,
   input logic signed [svg_pkg::POS_W-1:0] rsp_pos_z,
   input logic [svg_pkg::TEX_W-1:0]        rsp_tex_u,
   input logic [svg_pkg::TEX_W-1:0]        rsp_tex_v,
   input logic                             rsp_index_error
);
   import svg_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pos_x) && $stable(rsp_pos_y)
         && $stable(rsp_pos_z) && $stable(rsp_tex_u) && $stable(rsp_tex_v)
         && $stable(rsp_index_error))
      else $error("result changed while stalled");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_index_error |-> rsp_pos_x == '0 && rsp_pos_y == '0
         && rsp_pos_z == '0 && rsp_tex_u == '0 && rsp_tex_v == '0)
      else $error("error result carries nonzero fields");

   a_tex_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_tex_u <= 17'd65536 && rsp_tex_v <= 17'd65536)
      else $error("texture coordinate above one");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind uv_sphere_vertex_generator svg_port_checks u_svg_port_checks (.*);

### bench/svg_checker.sv
// ----------------------------------------------------------------------------
// svg_checker
// Watches the register, index and vertex channels of the UV sphere vertex
// generator, predicts every vertex from the register settings in force when
// its indexes are taken, and compares each returned vertex field by field.
// ----------------------------------------------------------------------------
module svg_checker #(
   parameter int MAX_SUBDIVISIONS = 1024,
   parameter int CORDIC_STEPS     = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  logic [svg_pkg::IDX_W-1:0]          req_ring_index,
   input  logic [svg_pkg::IDX_W-1:0]          req_segment_index,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic signed [svg_pkg::POS_W-1:0]   rsp_pos_x,
   input  logic signed [svg_pkg::POS_W-1:0]   rsp_pos_y,
   input  logic signed [svg_pkg::POS_W-1:0]   rsp_pos_z,
   input  logic [svg_pkg::TEX_W-1:0]          rsp_tex_u,
   input  logic [svg_pkg::TEX_W-1:0]          rsp_tex_v,
   input  logic                               rsp_index_error,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [svg_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [svg_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output int                                 vertices_pending,
   output int                                 mismatch_count
);
   import svg_pkg::*;

   typedef struct {
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic signed [POS_W-1:0] z;
      logic [TEX_W-1:0]        u;
      logic [TEX_W-1:0]        v;
      logic                    err;
   } vertex_type;

   vertex_type  vertex_queue[$];
   logic [10:0] subdiv_reg;
   logic [15:0] radius_reg;
   logic        textured_reg;

   function automatic longint round_off(input longint v, input int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   // rotation-mode CORDIC, 30 fraction bits, angle in 2^-32 turns
   function automatic void cordic(input logic [31:0] turns, output longint c,
                                  output longint s);
      logic   flip;
      logic [31:0] a;
      longint x, y, z, nx;
      int     steps;
      flip  = 1'b0;
      a     = turns;
      x     = 652032874;
      y     = 0;
      steps = (CORDIC_STEPS > ATAN_MAX) ? ATAN_MAX : CORDIC_STEPS;
      if (a >= 32'h4000_0000 && a < 32'hC000_0000) begin
         a    = a - 32'h8000_0000;
         flip = 1'b1;
      end
      z = longint'($signed(a));
      for (int i = 0; i < steps; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z  = z - longint'(atan_turns(i));
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z  = z + longint'(atan_turns(i));
         end
         x = nx;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic logic signed [POS_W-1:0] scaled(input longint unit);
      longint v;
      v = unit;
      if (textured_reg) begin
         v = round_off(unit * longint'(radius_reg), 8);
         if (v > 16777215) v = 16777215;
         if (v < -16777216) v = -16777216;
      end
      return v[POS_W-1:0];
   endfunction

   function automatic vertex_type vertex_of(input logic [10:0] ring,
                                            input logic [10:0] seg);
      vertex_type   e;
      longint       sd, ct, st, cp, sp, r;
      logic [63:0]  th, ph;
      sd = subdiv_reg;
      if (sd == 0) sd = 1;
      if (sd > MAX_SUBDIVISIONS) sd = MAX_SUBDIVISIONS;
      e = '{default: '0};
      if (ring > sd || seg > sd) begin
         e.err = 1'b1;
         return e;
      end
      th = ((64'(ring) << 31) + sd / 2) / sd;
      ph = ((64'(seg) << 32) + sd / 2) / sd;
      cordic(th[31:0], ct, st);
      cordic(ph[31:0], cp, sp);
      r   = (st < 0) ? -st : st;
      e.x = scaled(round_off(-cp * r, 44));
      e.y = scaled(round_off(-ct, 14));
      e.z = scaled(round_off(sp * r, 44));
      if (textured_reg) begin
         e.u = TEX_W'((longint'(seg) * 65536 + sd / 2) / sd);
         e.v = TEX_W'((longint'(ring) * 65536 + sd / 2) / sd);
      end
      return e;
   endfunction

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   initial mismatch_count = 0;

   always @(posedge clock) begin
      vertex_type e;
      if (reset) begin
         subdiv_reg   <= 11'd48;
         radius_reg   <= 16'd256;
         textured_reg <= 1'b0;
         vertex_queue.delete();
         vertices_pending <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SUBDIV: subdiv_reg   <= csr_wdata[10:0];
               CSR_RADIUS: radius_reg   <= csr_wdata;
               CSR_LAYOUT: textured_reg <= csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (vertex_queue.size() == 0) begin
               report("vertices outstanding", 1, 0);
            end else begin
               e = vertex_queue.pop_front();
               if (rsp_pos_x != e.x) report("pos_x", rsp_pos_x, e.x);
               if (rsp_pos_y != e.y) report("pos_y", rsp_pos_y, e.y);
               if (rsp_pos_z != e.z) report("pos_z", rsp_pos_z, e.z);
               if (rsp_tex_u != e.u) report("tex_u", rsp_tex_u, e.u);
               if (rsp_tex_v != e.v) report("tex_v", rsp_tex_v, e.v);
               if (rsp_index_error != e.err)
                  report("index_error", rsp_index_error, e.err);
            end
         end
         if (req_valid && req_ready)
            vertex_queue.insert(vertex_queue.size(),
                                vertex_of(req_ring_index, req_segment_index));
         vertices_pending <= vertex_queue.size();
      end
   end

endmodule

### bench/tb_uv_sphere_vertex_generator.sv
// ----------------------------------------------------------------------------
// tb_uv_sphere_vertex_generator
// Drives register settings and ring/segment items into the vertex generator
// with random gaps and back-pressure; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_uv_sphere_vertex_generator;
   import svg_pkg::*;

   localparam int WATCH_LIMIT = 5000;
   localparam int DRAIN       = 100;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [IDX_W-1:0]        req_ring_index = '0;
   logic [IDX_W-1:0]        req_segment_index = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic signed [POS_W-1:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic [TEX_W-1:0]        rsp_tex_u, rsp_tex_v;
   logic                    rsp_index_error;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index = CSR_SUBDIV;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;
   int                      vertices_pending, mismatch_count;
   logic                    steady = 1'b0;
   logic                    hold_request = 1'b0;
   int                      subdiv_now = 48;
   int                      quiet_cycles = 0;

   always #5 clock = ~clock;

   uv_sphere_vertex_generator dut (.*);

   svg_checker u_checker (.*);

   // vertex receiver; one long hold-off on request
   initial begin
      for (int k = 0; k < 11; k++) @(posedge clock);
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_ready <= 1'b0;
            for (int k = 0; k < 400; k++) @(posedge clock);
            hold_request <= 1'b0;
         end
         rsp_ready <= steady || ($urandom_range(99) >= 22);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCH_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      do @(negedge clock); while (!csr_ready);
      @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_SUBDIV) begin
         subdiv_now = value & 11'h7FF;
         if (subdiv_now == 0) subdiv_now = 1;
         if (subdiv_now > 1024) subdiv_now = 1024;
      end
   endtask

   task automatic send_vertex(input int ring, input int seg);
      // one idle cycle ahead of about 28 items in 100
      if (!steady && $urandom_range(99) < 28) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_ring_index    <= IDX_W'(ring);
      req_segment_index <= IDX_W'(seg);
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
   endtask

   task automatic settle;
      req_valid <= 1'b0;
      while (vertices_pending != 0) @(posedge clock);
      for (int k = 0; k < DRAIN; k++) @(posedge clock);
   endtask

   task automatic random_vertices(input int count);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < 90)
            send_vertex($urandom_range(subdiv_now), $urandom_range(subdiv_now));
         else
            send_vertex($urandom_range(2047), $urandom_range(2047));
      end
   endtask

   initial begin
      int subdivs[8]  = '{1, 1024, 2047, 0, 7, 1024, 100, 5};
      int radii[8]    = '{65535, 65535, 0, 256, 300, 128, 65535, 1};
      int layouts[8]  = '{1, 1, 1, 0, 1, 0, 1, 1};
      for (int k = 0; k < 11; k++) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: poles, equator, seam, out-of-range and all-ones indexes
      send_vertex(0, 0);
      send_vertex(48, 48);
      send_vertex(24, 12);
      send_vertex(12, 36);
      send_vertex(49, 0);
      send_vertex(0, 49);
      send_vertex(2047, 2047);
      send_vertex(1024, 1024);
      send_vertex(1, 47);
      settle();
      write_reg(CSR_SUBDIV, 1024);
      write_reg(CSR_RADIUS, 65535);
      write_reg(CSR_LAYOUT, 1);
      send_vertex(0, 1024);
      send_vertex(1024, 0);
      send_vertex(512, 256);
      send_vertex(1023, 1);
      send_vertex(1025, 3);
      send_vertex(1365, 682);
      send_vertex(682, 1365);
      settle();

      for (int ph = 0; ph < 9; ph++) begin
         if (ph < 8) begin
            write_reg(CSR_SUBDIV, subdivs[ph]);
            write_reg(CSR_RADIUS, radii[ph]);
            write_reg(CSR_LAYOUT, layouts[ph]);
         end else begin
            write_reg(CSR_SUBDIV, $urandom_range(1, 1024));
            write_reg(CSR_RADIUS, $urandom_range(65535));
            write_reg(CSR_LAYOUT, $urandom_range(1));
         end
         steady = (ph == 3);
         if (ph == 2) hold_request <= 1'b1;
         random_vertices(125);
         settle();
      end
      steady = 1'b0;

      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
